// File: rtl/allux_pkg.sv
// ----------------------------------------------------------------------------
// allux_pkg
// types, codes and constants shared by the ambient light lux blocks
// ----------------------------------------------------------------------------
package allux_pkg;

  typedef struct packed {
    logic [15:0] broadband_count;
    logic [15:0] infrared_count;
    logic        bus_error;
  } in_item_t;

  typedef struct packed {
    logic [31:0] lux_value;
    logic [15:0] infrared_out;
    logic [23:0] broadband_out;
    logic        reading_valid;
    logic        gain_used;
    logic        retry_request;
  } out_item_t;

  // configuration register indexes
  localparam logic CFG_GAIN_MODE = 1'b0;
  localparam logic CFG_INTEG_SEL = 1'b1;

  // gain modes
  localparam logic [1:0] MODE_FIXED_1X  = 2'd0;
  localparam logic [1:0] MODE_FIXED_16X = 2'd1;
  localparam logic [1:0] MODE_AUTO_EXT  = 2'd3;

  // integration select codes
  localparam logic [1:0] INTEG_SHORT  = 2'd0;
  localparam logic [1:0] INTEG_MEDIUM = 2'd1;
  localparam logic [1:0] INTEG_RESET  = 2'd2;

  // saturation limits
  localparam logic [15:0] LIMIT_SHORT  = 16'd5047;
  localparam logic [15:0] LIMIT_MEDIUM = 16'd37177;
  localparam logic [15:0] LIMIT_FULL   = 16'd65535;

  // time scale to 402 ms, 16 fraction bits
  localparam logic [20:0] SCALE_SHORT  = 21'd1923027;
  localparam logic [20:0] SCALE_MEDIUM = 21'd260846;
  localparam logic [20:0] SCALE_FULL   = 21'd65536;

  // coefficients, 24 fraction bits
  localparam logic [19:0] COEF_A0 = 20'd510027;
  localparam logic [19:0] COEF_B0 = 20'd1040187;
  localparam logic [19:0] COEF_A1 = 20'd375810;
  localparam logic [19:0] COEF_B1 = 20'd520094;
  localparam logic [19:0] COEF_A2 = 20'd214748;
  localparam logic [19:0] COEF_B2 = 20'd256691;
  localparam logic [19:0] COEF_A3 = 20'd24495;
  localparam logic [19:0] COEF_B3 = 20'd18790;

  localparam int LUX_LOW_THRESHOLD = 40;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_IDX,
    ST_DIV_IDX,
    ST_LUX_TABLE,
    ST_LUX_TERMS,
    ST_LUX_PART,
    ST_LUX_SUM,
    ST_DECIDE,
    ST_DIV_RATIO,
    ST_DIV_REB,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_INDEX,
    DIV_RATIO,
    DIV_REBUILD
  } div_sel_t;

  typedef enum logic [2:0] {
    LUX_NONE,
    LUX_TABLE,
    LUX_TERMS,
    LUX_PART,
    LUX_SUM
  } lux_step_t;

  typedef struct packed {
    logic      load;
    logic      div_start;
    div_sel_t  div_sel;
    lux_step_t lux_step;
    logic      meas_gain;
    logic      out_load;
    logic      out_bus_err;
    logic      out_valid_flag;
    logic      out_retry;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic raw_ok;
    logic sat16;
    logic ratio_ok;
    logic ratio_nz;
    logic lux_low;
  } status_t;

  // y, then n-1 times a = floor(a*y / 2^16)
  function automatic longint chain_pow(longint y, int n);
    longint a;
    a = y;
    for (int k = 1; k < n; k++) begin
      a = (a * y) >> 16;
    end
    return a;
  endfunction

  // r^1.4 table entry: largest y with y^5 <= i/(2n), then y^7
  function automatic logic [16:0] pow_entry(int i, int n);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = 65536;
    for (int it = 0; it < 18; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (chain_pow(mid, 5) * 2 * longint'(n) <= (longint'(i) << 16)) lo = mid;
        else hi = mid - 1;
      end
    end
    return 17'(chain_pow(lo, 7));
  endfunction

endpackage

// File: rtl/allux_dpath.sv
// ----------------------------------------------------------------------------
// allux_dpath
// count registers, shared divider, lux multiply stages and result register
// ----------------------------------------------------------------------------
module allux_dpath #(
  parameter int POWER_TABLE_ENTRIES = 256,
  parameter int LUX_FRACTION_BITS   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  allux_pkg::in_item_t in_data,
  input  logic                integ_we,
  input  logic [1:0]          cfg_data,
  input  allux_pkg::cmd_t     cmd,
  output allux_pkg::status_t  status,
  output allux_pkg::out_item_t out_data
);

  localparam int IDXW  = $clog2(POWER_TABLE_ENTRIES);
  localparam int TWO_N = 2 * POWER_TABLE_ENTRIES;
  localparam int SHIFT = 40 - LUX_FRACTION_BITS;

  typedef enum logic [2:0] {
    RNG_POW,
    RNG_LIN1,
    RNG_LIN2,
    RNG_LIN3,
    RNG_NONE
  } range_t;

  logic [1:0]      integ;
  logic [23:0]     bb;
  logic [15:0]     ch1;
  logic [19:0]     ratio;
  logic [IDXW-1:0] idx;
  logic [20:0]     sub_q;
  logic [42:0]     d_q;
  logic [42:0]     prod_lo;
  logic [31:0]     lux_q;

  logic [31:0]     dv_quo;
  logic [23:0]     dv_rem;
  logic [23:0]     dv_dsr;
  logic [4:0]      dv_cnt;
  logic            dv_busy;
  logic            dv_done;
  allux_pkg::div_sel_t dv_sel;

  logic [16:0] pow_tab [POWER_TABLE_ENTRIES];

  for (genvar g = 0; g < POWER_TABLE_ENTRIES; g++) begin : g_tab
    localparam logic [16:0] ENTRY = allux_pkg::pow_entry(g, POWER_TABLE_ENTRIES);
    assign pow_tab[g] = ENTRY;
  end

  // limit and scale from integration time
  logic [15:0] limit;
  logic [20:0] scale;
  always_comb begin
    unique case (integ)
      allux_pkg::INTEG_SHORT: begin
        limit = allux_pkg::LIMIT_SHORT;
        scale = allux_pkg::SCALE_SHORT;
      end
      allux_pkg::INTEG_MEDIUM: begin
        limit = allux_pkg::LIMIT_MEDIUM;
        scale = allux_pkg::SCALE_MEDIUM;
      end
      default: begin
        limit = allux_pkg::LIMIT_FULL;
        scale = allux_pkg::SCALE_FULL;
      end
    endcase
  end

  // divider step
  logic [24:0] dv_shift;
  logic [24:0] dv_trial;
  assign dv_shift = {dv_rem, dv_quo[31]};
  assign dv_trial = dv_shift - {1'b0, dv_dsr};

  // ratio ranges of ch1/ch0
  range_t rng;
  logic [31:0] a0w;
  logic [31:0] a1w;
  assign a0w = 32'(bb);
  assign a1w = 32'(ch1);
  always_comb begin
    priority if (2 * a1w < a0w)        rng = RNG_POW;
    else if (100 * a1w < 61 * a0w)     rng = RNG_LIN1;
    else if (5 * a1w < 4 * a0w)        rng = RNG_LIN2;
    else if (10 * a1w < 13 * a0w)      rng = RNG_LIN3;
    else                               rng = RNG_NONE;
  end

  logic [19:0] coef;
  logic [19:0] ca;
  logic [19:0] cb;
  logic [43:0] t0;
  logic [43:0] t1;
  always_comb begin
    coef = (sub_q < 21'(allux_pkg::COEF_A0)) ?
           20'(21'(allux_pkg::COEF_A0) - sub_q) : 20'd0;
    unique case (rng)
      RNG_POW:  begin ca = coef;                 cb = 20'd0;                end
      RNG_LIN1: begin ca = allux_pkg::COEF_A1;   cb = allux_pkg::COEF_B1;   end
      RNG_LIN2: begin ca = allux_pkg::COEF_A2;   cb = allux_pkg::COEF_B2;   end
      RNG_LIN3: begin ca = allux_pkg::COEF_A3;   cb = allux_pkg::COEF_B3;   end
      default:  begin ca = 20'd0;                cb = 20'd0;                end
    endcase
    t0 = 44'(ca) * 44'(bb);
    t1 = 44'(cb) * 44'(ch1);
  end

  // high partial product and final sum
  logic [67:0] full;
  logic [67:0] scaled;
  logic [67:0] shifted;
  always_comb begin
    full    = 68'(prod_lo) + (68'(68'(d_q[42:22]) * 68'(scale)) << 22);
    scaled  = cmd.meas_gain ? full : (full << 4);
    shifted = scaled >> SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ   <= allux_pkg::INTEG_RESET;
      ratio   <= 20'd0;
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
    end else begin
      dv_done <= !cmd.div_start && dv_busy && (dv_cnt == 5'd31);
      if (integ_we) integ <= cfg_data;
      if (cmd.load) begin
        bb  <= 24'(in_data.broadband_count);
        ch1 <= in_data.infrared_count;
      end
      if (cmd.div_start) begin
        dv_busy <= 1'b1;
        dv_cnt  <= 5'd0;
        dv_rem  <= 24'd0;
        dv_sel  <= cmd.div_sel;
        unique case (cmd.div_sel)
          allux_pkg::DIV_INDEX: begin
            dv_quo <= 32'(ch1) * 32'(TWO_N);
            dv_dsr <= bb;
          end
          allux_pkg::DIV_RATIO: begin
            dv_quo <= {ch1, 16'd0};
            dv_dsr <= bb;
          end
          default: begin
            dv_quo <= {ch1, 16'd0};
            dv_dsr <= 24'(ratio);
          end
        endcase
      end else if (dv_busy) begin
        if (!dv_trial[24]) begin
          dv_rem <= dv_trial[23:0];
          dv_quo <= {dv_quo[30:0], 1'b1};
        end else begin
          dv_rem <= dv_shift[23:0];
          dv_quo <= {dv_quo[30:0], 1'b0};
        end
        dv_cnt <= dv_cnt + 5'd1;
        if (dv_cnt == 5'd31) begin
          dv_busy <= 1'b0;
        end
      end
      if (dv_done) begin
        unique case (dv_sel)
          allux_pkg::DIV_INDEX:
            idx <= (dv_quo >= 32'(POWER_TABLE_ENTRIES)) ?
                   IDXW'(POWER_TABLE_ENTRIES - 1) : dv_quo[IDXW-1:0];
          allux_pkg::DIV_RATIO:
            ratio <= (|dv_quo[31:20]) ? 20'hFFFFF : dv_quo[19:0];
          default:
            bb <= (|dv_quo[31:24]) ? 24'hFFFFFF : dv_quo[23:0];
        endcase
      end
    end
  end

  // lux stages
  always_ff @(posedge clk) begin
    unique case (cmd.lux_step)
      allux_pkg::LUX_TABLE:
        sub_q <= 21'((37'(allux_pkg::COEF_B0) * 37'(pow_tab[idx])) >> 16);
      allux_pkg::LUX_TERMS:
        d_q <= (t0 > t1) ? 43'(t0 - t1) : 43'd0;
      allux_pkg::LUX_PART:
        prod_lo <= 43'(d_q[21:0]) * 43'(scale);
      allux_pkg::LUX_SUM:
        lux_q <= (|shifted[67:32]) ? 32'hFFFFFFFF : shifted[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_bus_err) begin
        out_data.lux_value     <= 32'd0;
        out_data.infrared_out  <= 16'd0;
        out_data.broadband_out <= 24'd0;
        out_data.reading_valid <= 1'b0;
        out_data.retry_request <= 1'b0;
      end else begin
        out_data.lux_value     <= lux_q;
        out_data.infrared_out  <= ch1;
        out_data.broadband_out <= bb;
        out_data.reading_valid <= cmd.out_valid_flag;
        out_data.retry_request <= cmd.out_retry;
      end
      out_data.gain_used <= cmd.meas_gain;
    end
  end

  always_comb begin
    status.div_done = dv_done;
    status.raw_ok   = (bb < 24'(limit)) && (ch1 < limit);
    status.sat16    = {bb, 4'd0} >= 28'(limit);
    status.ratio_ok = (bb != 24'd0) && ({bb, 1'b0} < 25'(limit)) &&
                      ({ch1, 1'b0} < 17'(limit));
    status.ratio_nz = ratio != 20'd0;
    status.lux_low  = lux_q < (32'(allux_pkg::LUX_LOW_THRESHOLD) << LUX_FRACTION_BITS);
  end

endmodule

// File: rtl/allux_ctrl.sv
// ----------------------------------------------------------------------------
// allux_ctrl
// sequencer for one reading: gain flag, retry flag and result handshake
// ----------------------------------------------------------------------------
module allux_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               bus_error,
  input  logic               mode_we,
  input  logic [1:0]         cfg_data,
  input  logic               out_stall,
  input  allux_pkg::status_t status,
  output logic               in_stall,
  output logic               out_valid,
  output allux_pkg::cmd_t    cmd
);

  allux_pkg::state_t state;
  allux_pkg::state_t state_next;

  logic [1:0] gain_mode;
  logic       high_gain;
  logic       retry_pending;
  logic       meas_gain;
  logic       err;
  logic       rebuilt;
  logic       res_valid;
  logic       auto_mode;
  logic       retry;

  assign auto_mode = gain_mode[1];
  assign retry     = !err && !res_valid && auto_mode && !retry_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= allux_pkg::ST_IDLE;
      gain_mode     <= allux_pkg::MODE_FIXED_1X;
      high_gain     <= 1'b0;
      retry_pending <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        meas_gain <= high_gain;
        err       <= bus_error;
        rebuilt   <= 1'b0;
      end
      if (state == allux_pkg::ST_DECIDE) begin
        // a saturated reading that gets rebuilt counts as valid
        res_valid <= status.raw_ok ||
                     (status.ratio_nz && gain_mode == allux_pkg::MODE_AUTO_EXT);
        if (auto_mode) begin
          if (high_gain) begin
            if (status.sat16) high_gain <= 1'b0;
          end else if (status.lux_low) begin
            high_gain <= 1'b1;
          end
        end
      end
      if (cmd.div_start && cmd.div_sel == allux_pkg::DIV_REBUILD) begin
        rebuilt <= 1'b1;
      end
      if (mode_we) begin
        gain_mode <= cfg_data;
        high_gain <= cfg_data == allux_pkg::MODE_FIXED_16X;
      end
      if (cmd.out_load) begin
        retry_pending <= retry;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next         = state;
    in_stall           = 1'b1;
    cmd                = '0;
    cmd.div_sel        = allux_pkg::DIV_INDEX;
    cmd.lux_step       = allux_pkg::LUX_NONE;
    cmd.meas_gain      = meas_gain;
    cmd.out_bus_err    = err;
    cmd.out_valid_flag = res_valid;
    cmd.out_retry      = retry;
    unique case (state)
      allux_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = bus_error ? allux_pkg::ST_FINISH : allux_pkg::ST_START_IDX;
        end
      end
      allux_pkg::ST_START_IDX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = allux_pkg::DIV_INDEX;
        state_next    = allux_pkg::ST_DIV_IDX;
      end
      allux_pkg::ST_DIV_IDX: begin
        if (status.div_done) state_next = allux_pkg::ST_LUX_TABLE;
      end
      allux_pkg::ST_LUX_TABLE: begin
        cmd.lux_step = allux_pkg::LUX_TABLE;
        state_next   = allux_pkg::ST_LUX_TERMS;
      end
      allux_pkg::ST_LUX_TERMS: begin
        cmd.lux_step = allux_pkg::LUX_TERMS;
        state_next   = allux_pkg::ST_LUX_PART;
      end
      allux_pkg::ST_LUX_PART: begin
        cmd.lux_step = allux_pkg::LUX_PART;
        state_next   = allux_pkg::ST_LUX_SUM;
      end
      allux_pkg::ST_LUX_SUM: begin
        cmd.lux_step = allux_pkg::LUX_SUM;
        state_next   = rebuilt ? allux_pkg::ST_FINISH : allux_pkg::ST_DECIDE;
      end
      allux_pkg::ST_DECIDE: begin
        if (status.raw_ok) begin
          if (status.ratio_ok) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = allux_pkg::DIV_RATIO;
            state_next    = allux_pkg::ST_DIV_RATIO;
          end else begin
            state_next = allux_pkg::ST_FINISH;
          end
        end else if (status.ratio_nz && gain_mode == allux_pkg::MODE_AUTO_EXT) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = allux_pkg::DIV_REBUILD;
          state_next    = allux_pkg::ST_DIV_REB;
        end else begin
          state_next = allux_pkg::ST_FINISH;
        end
      end
      allux_pkg::ST_DIV_RATIO: begin
        if (status.div_done) state_next = allux_pkg::ST_FINISH;
      end
      allux_pkg::ST_DIV_REB: begin
        if (status.div_done) state_next = allux_pkg::ST_START_IDX;
      end
      allux_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = allux_pkg::ST_IDLE;
        end
      end
      default: state_next = allux_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/ambient_light_lux_autogain.sv
// ----------------------------------------------------------------------------
// ambient_light_lux_autogain
// lux from broadband and infrared counts with auto gain, ratio keeping,
// saturated count rebuild and one retry request
// ----------------------------------------------------------------------------
//  channel | signals                      | transfer when
//  --------+------------------------------+-----------------------------
//  in      | in_valid in_stall in_data    | in_valid  & !in_stall
//  out     | out_valid out_stall out_data | out_valid & !out_stall
//  cfg     | cfg_valid cfg_ready          | cfg_valid & cfg_ready
//          | cfg_index cfg_data           |
//
// sequence: a bus error reading goes straight to its result; a normal reading
// runs the index division and 4 lux stages, plus a ratio division when the
// ratio is kept, and a saturated count is rebuilt by a rebuild division,
// second index division and second lux pass; the shared divider makes one
// quotient bit a cycle
// reset: rst is synchronous; registers come up 1x gain, 402 ms, no ratio
// stalls: a finished result sits in the output register while the next
// reading is accepted; a result waits in its last step only while the
// output register is still full and stalled
// ----------------------------------------------------------------------------
module ambient_light_lux_autogain #(
  parameter int POWER_TABLE_ENTRIES = 256,
  parameter int LUX_FRACTION_BITS   = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  allux_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output allux_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [1:0]           cfg_data
);

  allux_pkg::cmd_t    cmd;
  allux_pkg::status_t status;
  logic               cfg_we;
  logic               mode_we;
  logic               integ_we;

  // config is to be written only while idle (not enforced here), so always ready
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign mode_we   = cfg_we && cfg_index == allux_pkg::CFG_GAIN_MODE;
  assign integ_we  = cfg_we && cfg_index == allux_pkg::CFG_INTEG_SEL;

  // sequencer: gain flag, retry flag, output valid
  allux_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .bus_error (in_data.bus_error),
    .mode_we   (mode_we),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // counts, divider, lux stages, kept ratio, result register
  allux_dpath #(
    .POWER_TABLE_ENTRIES (POWER_TABLE_ENTRIES),
    .LUX_FRACTION_BITS   (LUX_FRACTION_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .integ_we (integ_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// File: rtl/allux_chk.sv
// ----------------------------------------------------------------------------
// allux_chk
// port level checks for the ambient light lux block
// ----------------------------------------------------------------------------
module allux_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input allux_pkg::out_item_t out_data
);

  // one reading at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // retry is only asked for a failed reading
  a_retry_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.retry_request |-> !out_data.reading_valid)
    else $error("retry on valid reading");

  // reset leaves no result and an idle input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state after reset");

endmodule

bind ambient_light_lux_autogain allux_chk u_allux_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
